[rtl/symbol_table_cam_core_defines.svh]
// ----------------------------------------------------------------------------
// Symbol table CAM assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_TABLE_CAM_CORE_DEFINES_SVH
`define SYMBOL_TABLE_CAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define STC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// A condition that must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STC_ASSERT(lbl, expr, msg)
`define STC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// Symbol table CAM package
// Word types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int DEF_ENTRIES   = 16;
	localparam int DEF_KEY_BYTES = 8;

	localparam int MODE_W   = 2;
	localparam int SYM_W    = 64;
	localparam int TYPE_W   = 64;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int HIT_W    = 4;
	localparam int COUNT_W  = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SYM_W-1:0]  symbol_key;
		logic [TYPE_W-1:0] type_word;
		logic [LEN_W-1:0]  length_value;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HIT_W-1:0]    hit_index;
		logic [TYPE_W-1:0]   found_type;
		logic [LEN_W-1:0]    found_length;
		logic [COUNT_W-1:0]  entry_count;
	} out_word_t;

endpackage

[rtl/symbol_table_cam_core.sv]
// ----------------------------------------------------------------------------
// Symbol table CAM core
// Ordered associative table of symbol entries with insert, delete, search
// and modify requests, scanned one entry per cycle out of a single RAM.
// ----------------------------------------------------------------------------
// Usage:
// One request word enters on in_word when in_valid is high and in_stall is
// low. The block takes one request at a time and holds in_stall high until
// the request is finished; exactly one result word leaves on out_word.
// A request scans the valid entries in order, one RAM read per cycle, and
// stops at the first key match; a delete then also copies every later entry
// down by one. On an empty table an insert goes to the scan and misses at
// once, and any other request goes straight to its result. in_stall drops
// as out_valid rises, and the block is then ready for the next request.
// The result sits in an output register; a new request is accepted while it
// waits, and only the hand-off of the next result waits on out_stall.
// Reset empties the table at once; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
`include "symbol_table_cam_core_defines.svh"

module symbol_table_cam_core
	import stc_pkg::*;
#(
	parameter int ENTRIES   = DEF_ENTRIES,
	parameter int KEY_BYTES = DEF_KEY_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 8 * KEY_BYTES;
	localparam int ENTRY_W = KEY_W + TYPE_W + LEN_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   cmp_idx_q;
	logic               cmp_v_q;
	logic               out_valid_q;
	in_word_t           req_q;
	out_word_t          out_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [HIT_W-1:0]   res_idx_q;
	logic [TYPE_W-1:0]  res_type_q;
	logic [LEN_W-1:0]   res_len_q;

	logic [ENTRY_W-1:0] mem [ENTRIES];
	logic [ENTRY_W-1:0] rd_data_q;

	logic               in_accept;
	logic               out_free;
	logic [KEY_W-1:0]   req_key;
	logic [KEY_W-1:0]   rd_key;
	logic [TYPE_W-1:0]  rd_type;
	logic [LEN_W-1:0]   rd_len;
	logic               can_issue;
	logic               at_last;
	logic               full;
	logic               hit;
	logic               miss;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               we;
	logic [IDX_W-1:0]   wa;
	logic [ENTRY_W-1:0] wd;
	logic [CNT_W-1:0]   shift_wa;
	logic [CNT_W+HIT_W-1:0]   idx_ext;
	logic [CNT_W+HIT_W-1:0]   ins_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign req_key = req_q.symbol_key[KEY_W-1:0];
	assign rd_key  = rd_data_q[ENTRY_W-1 -: KEY_W];
	assign rd_type = rd_data_q[LEN_W +: TYPE_W];
	assign rd_len  = rd_data_q[LEN_W-1:0];

	assign can_issue = (scan_q < count_q);
	assign at_last   = cmp_v_q && (cmp_idx_q == count_q - CNT_W'(1));
	assign full      = (count_q == CNT_W'(ENTRIES));
	assign hit       = (state_q == ST_SCAN) && cmp_v_q && (rd_key == req_key);
	assign miss      = (state_q == ST_SCAN) && !hit && (at_last || (count_q == '0));
	assign rd_en     = ((state_q == ST_SCAN) && !hit && !miss && can_issue)
		|| ((state_q == ST_SHIFT) && can_issue);
	assign rd_addr   = scan_q[IDX_W-1:0];
	assign shift_wa  = cmp_idx_q - CNT_W'(1);

	assign idx_ext = {{HIT_W{1'b0}}, cmp_idx_q};
	assign ins_ext = {{HIT_W{1'b0}}, count_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	always_comb begin
		we = 1'b0;
		wa = cmp_idx_q[IDX_W-1:0];
		wd = {req_key, req_q.type_word, req_q.length_value};
		if (state_q == ST_SHIFT) begin
			we = cmp_v_q;
			wa = shift_wa[IDX_W-1:0];
			wd = rd_data_q;
		end else if (miss && (req_q.mode == MODE_INSERT) && !full) begin
			we = 1'b1;
			wa = count_q[IDX_W-1:0];
		end else if (hit && (req_q.mode == MODE_MODIFY)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			cmp_idx_q   <= '0;
			cmp_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_v_q <= rd_en;
			if (rd_en) begin
				cmp_idx_q <= scan_q;
				scan_q    <= scan_q + CNT_W'(1);
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (in_accept) begin
						if ((in_word.mode != MODE_INSERT) && (count_q == '0)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						if (req_q.mode == MODE_DELETE) begin
							scan_q  <= cmp_idx_q + CNT_W'(1);
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (miss) begin
						if ((req_q.mode == MODE_INSERT) && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_SHIFT: begin
					if (!can_issue && !cmp_v_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q        <= in_word;
			res_status_q <= STAT_EMPTY;
			res_idx_q    <= '0;
			res_type_q   <= '0;
			res_len_q    <= '0;
		end
		if (hit) begin
			res_idx_q <= idx_ext[HIT_W-1:0];
			if (req_q.mode == MODE_INSERT) begin
				res_status_q <= STAT_DUPLICATE;
			end else begin
				res_status_q <= STAT_OK;
			end
			if ((req_q.mode == MODE_SEARCH) || (req_q.mode == MODE_MODIFY)) begin
				res_type_q <= rd_type;
				res_len_q  <= rd_len;
			end
		end else if (miss) begin
			if (req_q.mode != MODE_INSERT) begin
				res_status_q <= STAT_NOT_FOUND;
			end else if (full) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_OK;
				res_idx_q    <= ins_ext[HIT_W-1:0];
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.status       <= res_status_q;
			out_q.hit_index    <= res_idx_q;
			out_q.found_type   <= res_type_q;
			out_q.found_length <= res_len_q;
			out_q.entry_count  <= cnt_ext[COUNT_W-1:0];
		end
	end

	`STC_ASSERT(a_count_range, count_q <= CNT_W'(ENTRIES), "Entry count exceeds table size.")
	`STC_ASSERT_NEXT(a_accept_busy, in_accept, state_q != ST_IDLE, "Block idle after accepting a word.")
	`STC_ASSERT_NEXT(a_out_drain, out_valid_q && !out_stall && (state_q != ST_FIN), !out_valid_q, "Result word repeated.")
	`STC_ASSERT(a_shift_addr, !((state_q == ST_SHIFT) && cmp_v_q) || ((cmp_idx_q != '0) && (cmp_idx_q < count_q)), "Shift write outside valid entries.")

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Symbol table CAM core testbench
// Sends insert, delete, search and modify requests through the valid/stall
// handshake. A mirror of the symbol table predicts each result word, and
// every result word is compared field by field with the oldest prediction.
// Random gaps on both sides, two long output hold-offs and steady stretches
// vary the handshake timing.
// ----------------------------------------------------------------------------
module tb;

	import stc_pkg::*;

	localparam int ENTRIES    = DEF_ENTRIES;
	localparam int KEY_BYTES  = DEF_KEY_BYTES;
	localparam int POOL_SIZE  = 24;
	localparam int RAND_ITEMS = 1000;

	class symbol_table_mirror;

		localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

		logic [stc_pkg::SYM_W-1:0]  key_mem [ENTRIES];
		logic [stc_pkg::TYPE_W-1:0] type_mem [ENTRIES];
		logic [stc_pkg::LEN_W-1:0]  length_mem [ENTRIES];
		int used;
		int errors;
		stc_pkg::out_word_t pending_replies [$];

		function new();
			used = 0;
			errors = 0;
		endfunction

		function int find_entry(logic [stc_pkg::SYM_W-1:0] key);
			for (int i = 0; i < used; i++) begin
				if (key_mem[i] == key) begin
					return i;
				end
			end
			return -1;
		endfunction

		function stc_pkg::out_word_t predict_reply(stc_pkg::in_word_t req);
			stc_pkg::out_word_t rep;
			logic [stc_pkg::SYM_W-1:0] key;
			int pos;
			rep = '0;
			key = req.symbol_key & KEY_MASK;
			pos = find_entry(key);
			if (req.mode == stc_pkg::MODE_INSERT) begin
				if (pos >= 0) begin
					rep.status = stc_pkg::STAT_DUPLICATE;
					rep.hit_index = pos[stc_pkg::HIT_W-1:0];
				end else if (used >= ENTRIES) begin
					rep.status = stc_pkg::STAT_FULL;
				end else begin
					key_mem[used] = key;
					type_mem[used] = req.type_word;
					length_mem[used] = req.length_value;
					rep.status = stc_pkg::STAT_OK;
					rep.hit_index = used[stc_pkg::HIT_W-1:0];
					used++;
				end
			end else if (used == 0) begin
				rep.status = stc_pkg::STAT_EMPTY;
			end else if (pos < 0) begin
				rep.status = stc_pkg::STAT_NOT_FOUND;
			end else if (req.mode == stc_pkg::MODE_DELETE) begin
				for (int k = pos; k + 1 < used; k++) begin
					key_mem[k] = key_mem[k + 1];
					type_mem[k] = type_mem[k + 1];
					length_mem[k] = length_mem[k + 1];
				end
				used--;
				rep.status = stc_pkg::STAT_OK;
				rep.hit_index = pos[stc_pkg::HIT_W-1:0];
			end else begin
				rep.status = stc_pkg::STAT_OK;
				rep.hit_index = pos[stc_pkg::HIT_W-1:0];
				rep.found_type = type_mem[pos];
				rep.found_length = length_mem[pos];
				if (req.mode == stc_pkg::MODE_MODIFY) begin
					type_mem[pos] = req.type_word;
					length_mem[pos] = req.length_value;
				end
			end
			rep.entry_count = used[stc_pkg::COUNT_W-1:0];
			return rep;
		endfunction

		task report(string msg);
			if (errors < 100) begin
				$display("mismatch: %s", msg);
			end
			errors++;
		endtask

		task note_request(stc_pkg::in_word_t req);
			pending_replies.push_back(predict_reply(req));
		endtask

		task check_result(stc_pkg::out_word_t got);
			stc_pkg::out_word_t exp;
			if (pending_replies.size() == 0) begin
				report("result word with no request pending");
				return;
			end
			exp = pending_replies.pop_front();
			if (got.status != exp.status) begin
				report($sformatf("status %0d, expected %0d", got.status, exp.status));
			end
			if (got.hit_index != exp.hit_index) begin
				report($sformatf("hit_index %0d, expected %0d",
					got.hit_index, exp.hit_index));
			end
			if (got.found_type != exp.found_type) begin
				report($sformatf("found_type %h, expected %h",
					got.found_type, exp.found_type));
			end
			if (got.found_length != exp.found_length) begin
				report($sformatf("found_length %h, expected %h",
					got.found_length, exp.found_length));
			end
			if (got.entry_count != exp.entry_count) begin
				report($sformatf("entry_count %0d, expected %0d",
					got.entry_count, exp.entry_count));
			end
		endtask

	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	bit steady = 1'b0;
	logic [SYM_W-1:0] key_pool [POOL_SIZE];

	symbol_table_mirror mirror;

	symbol_table_cam_core #(
		.ENTRIES(ENTRIES),
		.KEY_BYTES(KEY_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always #5 clk = ~clk;

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task send_request(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] key,
			logic [TYPE_W-1:0] tword, logic [LEN_W-1:0] len);
		in_word_t req;
		int gap;
		req.mode = mode;
		req.symbol_key = key;
		req.type_word = tword;
		req.length_value = len;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= req;
		do @(posedge clk); while (in_stall);
		mirror.note_request(req);
	endtask

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int hold;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 250 || taken == 650) begin
				hold = 200;
			end else if (steady) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 5);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			mirror.check_result(out_word);
			taken++;
		end
	end

	initial begin
		int r;
		bit insert_heavy;
		logic [MODE_W-1:0] mode;
		logic [SYM_W-1:0] key;
		mirror = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			key_pool[i] = rand64();
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_SEARCH, key_pool[0], rand64(), 16'($urandom));
		send_request(MODE_DELETE, key_pool[1], rand64(), 16'($urandom));
		send_request(MODE_MODIFY, key_pool[2], rand64(), 16'($urandom));
		send_request(MODE_INSERT, key_pool[0], '1, 16'hFFFF);
		send_request(MODE_INSERT, key_pool[1], '0, 16'h0000);
		send_request(MODE_INSERT, key_pool[0], rand64(), 16'($urandom));
		send_request(MODE_SEARCH, key_pool[2], '0, '0);
		send_request(MODE_MODIFY, key_pool[1], rand64(), 16'($urandom));
		send_request(MODE_SEARCH, key_pool[1], '0, '0);
		for (int i = 2; i < ENTRIES; i++) begin
			send_request(MODE_INSERT, key_pool[i], rand64(), 16'($urandom));
		end
		send_request(MODE_INSERT, key_pool[ENTRIES], rand64(), 16'($urandom));
		send_request(MODE_INSERT, key_pool[5], rand64(), 16'($urandom));
		send_request(MODE_DELETE, key_pool[8], '0, '0);
		send_request(MODE_DELETE, key_pool[0], '0, '0);
		send_request(MODE_DELETE, key_pool[ENTRIES - 1], '0, '0);
		send_request(MODE_SEARCH, key_pool[9], '0, '0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			steady = ((i / 100) % 4) == 3;
			insert_heavy = ((i / 125) % 2) == 0;
			r = $urandom_range(0, 99);
			if (insert_heavy) begin
				mode = (r < 50) ? MODE_INSERT : (r < 65) ? MODE_DELETE :
					(r < 85) ? MODE_SEARCH : MODE_MODIFY;
			end else begin
				mode = (r < 20) ? MODE_INSERT : (r < 55) ? MODE_DELETE :
					(r < 80) ? MODE_SEARCH : MODE_MODIFY;
			end
			if ($urandom_range(0, 9) == 0) begin
				key = rand64();
			end else begin
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			send_request(mode, key, rand64(), 16'($urandom));
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (mirror.pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mirror.pending_replies.size() != 0) begin
			mirror.report("result words still pending at the end");
		end
		if (mirror.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/stc_pkg.sv
rtl/symbol_table_cam_core.sv
tb/sv/tb.sv
